// ===== src/fwmaf_pkg.sv =====
// fwmaf_pkg: shared constants and crc byte function for the flow weighted mean anomaly flag
// no dependencies
package fwmaf_pkg;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_SEED = 32'h00000001;
  localparam logic [15:0] TIME_WEIGHT = 16'd45875;
  localparam logic [15:0] LEN_WEIGHT = 16'd19660;
  localparam int FRAC_BITS = 16;
  localparam int SCORE_SHIFT = 11;
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] REG_WEIGHT_WINDOW = 2'd1;
  localparam logic [1:0] REG_WEIGHT_HISTORY = 2'd2;

  // one crc byte step, eight dependent bit steps on a 32-bit value
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction
endpackage

// ===== src/flow_weighted_mean_anomaly_flag.sv =====
// flow_weighted_mean_anomaly_flag: per-flow score, window mean and anomaly flag
// depends on fwmaf_pkg, fwmaf_ram, fwmaf_div
// sequence per request: 8 hash byte steps, read, update, write back, result, idle; a
//   window close adds divider start, 32 quotient bits, done and two multiply steps, all
//   set by the sequencer over the single bucket state memory; a new request is taken
//   only after the previous result is accepted
// reset: counters and fsm cleared and configuration set to (64, 19660, 45875) at once, then a
//   clearing pass writes zero to all DEPTH (256 by default) bucket entries, one per cycle, before requests
module flow_weighted_mean_anomaly_flag #(
  parameter int BUCKET_MASK = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [31:0] metric_time,
  input  logic [31:0] metric_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        analyze,
  output logic [31:0] packet_total,
  output logic [31:0] flagged_total,
  output logic [31:0] history_mean,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import fwmaf_pkg::*;

  localparam int AW = $clog2(BUCKET_MASK + 1);
  localparam int DEPTH = 1 << AW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_HASH = 4'd2;
  localparam logic [3:0] S_READ = 4'd3;
  localparam logic [3:0] S_UPD = 4'd4;
  localparam logic [3:0] S_DIV = 4'd5;
  localparam logic [3:0] S_MUL = 4'd6;
  localparam logic [3:0] S_WB = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0] state;

  // configuration registers
  logic [15:0] window_length;
  logic [16:0] weight_window_mean;
  logic [16:0] weight_history;

  assign cfg_ready = 1'b1;

  // request capture
  logic [31:0] src_r, dst_r, mt_r, ml_r;
  logic [31:0] crc;
  logic [3:0]  crc_step;
  logic [AW-1:0] bucket;
  logic [AW-1:0] clr_addr;

  // bucket state memory: count, sum, mean packed in one word
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [95:0]    ram_wdata;
  logic [95:0]    ram_rdata;

  fwmaf_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_state (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (bucket),
    .rdata (ram_rdata)
  );

  // score pipeline, one 32x16 product each
  logic [47:0] prod_t, prod_l;
  logic [31:0] score;
  logic [32:0] score_sum_w;

  logic [31:0] cnt_new, sum_new, mean_old, mean_new;
  logic        flag;
  logic        closing;

  // flag and window close decided from the memory word while in update
  logic        flag_next;
  logic        closing_next;

  assign flag_next = (score > ram_rdata[95:64]) && (ram_rdata[95:64] != 32'd0);
  assign closing_next = (window_length != 16'd0) &&
                        (ram_rdata[31:0] + 32'd1 == {16'd0, window_length});

  logic        div_start, div_done;
  logic [31:0] wmean;
  logic [48:0] mul_a, mul_b;
  logic [1:0]  mul_step;

  fwmaf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (window_length),
    .done     (div_done),
    .quotient (wmean)
  );

  logic [31:0] packet_counter, flagged_counter;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign packet_total = packet_counter;
  assign flagged_total = flagged_counter;

  assign score_sum_w = {1'b0, prod_t[47:16]} + {1'b0, prod_l[47:16]};

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = bucket;
    ram_wdata = {mean_new, sum_new, cnt_new};
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_WB) begin
      ram_we = 1'b1;
      if (closing) begin
        ram_wdata = {mean_new, 64'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      window_length <= 16'd64;
      weight_window_mean <= 17'd19660;
      weight_history <= 17'd45875;
      packet_counter <= '0;
      flagged_counter <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LENGTH:  window_length <= cfg_data[15:0];
          REG_WEIGHT_WINDOW:  weight_window_mean <= cfg_data;
          REG_WEIGHT_HISTORY: weight_history <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (crc_step == 4'd7) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_UPD;
        S_UPD: begin
          packet_counter <= packet_counter + 32'd1;
          if (flag_next) begin
            flagged_counter <= flagged_counter + 32'd1;
          end
          if (closing_next) begin
            state <= S_DIV;
            div_start <= 1'b1;
          end else begin
            state <= S_WB;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_step == 2'd1) begin
            state <= S_WB;
          end
        end
        S_WB: state <= S_OUT;
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        src_r <= src_addr;
        dst_r <= dst_addr;
        mt_r <= metric_time;
        ml_r <= metric_length;
        crc <= CRC_SEED;
        crc_step <= '0;
      end
      S_HASH: begin
        // one byte per cycle, source word then destination, msb first
        if (crc_step[2]) begin
          crc <= crc_byte(crc, dst_r[31:24]);
          dst_r <= {dst_r[23:0], 8'd0};
        end else begin
          crc <= crc_byte(crc, src_r[31:24]);
          src_r <= {src_r[23:0], 8'd0};
        end
        crc_step <= crc_step + 4'd1;
        prod_t <= mt_r * TIME_WEIGHT;
        prod_l <= ml_r * LEN_WEIGHT;
        if (crc_step == 4'd7) begin
          bucket <= AW'(crc_byte(crc, dst_r[31:24]) & 32'(BUCKET_MASK));
        end
      end
      S_READ: begin
        score <= 32'(score_sum_w >> SCORE_SHIFT);
      end
      S_UPD: begin
        cnt_new <= ram_rdata[31:0] + 32'd1;
        sum_new <= ram_rdata[63:32] + score;
        mean_old <= ram_rdata[95:64];
        mean_new <= ram_rdata[95:64];
        flag <= flag_next;
        closing <= closing_next;
        mul_step <= '0;
      end
      S_MUL: begin
        mul_step <= mul_step + 2'd1;
        if (mul_step == 2'd0) begin
          mul_a <= wmean * weight_window_mean;
          mul_b <= mean_old * weight_history;
        end else if (mean_old == 32'd0) begin
          mean_new <= wmean;
        end else begin
          mean_new <= 32'(mul_a[48:16]) + 32'(mul_b[48:16]);
        end
      end
      S_WB: begin
        analyze <= flag;
        history_mean <= mean_new;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_HASH))
    else $error("request not taken into hash");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && !closing_next) |=> (state == S_WB))
    else $error("non-closing update skipped writeback");
  assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output overlap");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");
endmodule

// ===== src/fwmaf_ram.sv =====
// fwmaf_ram: generic single write port ram with registered read
// no dependencies
module fwmaf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/fwmaf_div.sv =====
// fwmaf_div: radix-2 restoring divider, 32-bit dividend by 16-bit divisor
// depends on nothing; one quotient bit per cycle
module fwmaf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] rem;
  logic [31:0] q;
  logic [15:0] dv;
  logic [16:0] shifted;
  logic [17:0] diff;

  assign shifted = {rem[15:0], q[31]};
  assign diff = {1'b0, shifted} - {2'b0, dv};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q <= dividend;
      dv <= divisor;
    end else if (busy) begin
      if (!diff[17]) begin
        rem <= diff[16:0];
      end else begin
        rem <= shifted;
      end
      q <= {q[30:0], ~diff[17]};
    end
  end
endmodule
